// File: rtl/rgba_3x3_convolution_assert.svh
// Assertion macros shared by the convolution block.
`ifndef RGBA_3X3_CONVOLUTION_ASSERT_SVH
`define RGBA_3X3_CONVOLUTION_ASSERT_SVH

// The condition must never hold at a clock edge outside reset.
`define RC3_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) else $error(msg);

// When the first expression holds, the second must hold in the same cycle.
`define RC3_ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// File: rtl/rc3_pkg.sv
`default_nettype none
package rc3_pkg;

    // Line store depth and the widths that follow from the supported image size.
    localparam int MAX_WIDTH = 1024;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int DIM_W     = 11;
    localparam int ROW_W     = 11;
    localparam int OPC_W     = 21;
    localparam int ACC_W     = 20;
    localparam int REM_W     = 16;

    // Configuration register indexes.
    localparam logic [2:0] CFG_WIDTH  = 3'd0;
    localparam logic [2:0] CFG_HEIGHT = 3'd1;
    localparam logic [2:0] CFG_TOP    = 3'd2;
    localparam logic [2:0] CFG_MID    = 3'd3;
    localparam logic [2:0] CFG_BOT    = 3'd4;
    localparam logic [2:0] CFG_DIV    = 3'd5;

    typedef logic [31:0] t_pix;

    // Effective configuration, already clamped to legal values.
    typedef struct packed {
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
        logic [23:0]      coef_top;
        logic [23:0]      coef_mid;
        logic [23:0]      coef_bot;
        logic [7:0]       divisor;
    } t_cfg;

    // One window request from the front to the back, index col*3 + row.
    typedef struct packed {
        logic [8:0][31:0] pix;
        logic [9:0]       row;
        logic [9:0]       col;
        logic             last;
    } t_job;

    typedef enum logic [1:0] {
        F_IDLE,
        F_READ,
        F_STEP
    } t_front_state;

    typedef enum logic [2:0] {
        B_IDLE,
        B_MAC,
        B_PREP,
        B_DIV,
        B_HOLD
    } t_back_state;

    // Clamp a written dimension to 1..MAX_WIDTH.
    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        r = v;
        if (v == '0) begin
            r = DIM_W'(1);
        end else if (v > DIM_W'(MAX_WIDTH)) begin
            r = DIM_W'(MAX_WIDTH);
        end
        return r;
    endfunction

    // Select the signed tap for window row r and column c.
    function automatic logic signed [7:0] coef_sel(input t_cfg cfg, input logic [1:0] r,
                                                    input logic [1:0] c);
        logic [23:0] rowreg;
        logic [7:0]  b;
        unique case (r)
            2'd0:    rowreg = cfg.coef_top;
            2'd1:    rowreg = cfg.coef_mid;
            default: rowreg = cfg.coef_bot;
        endcase
        unique case (c)
            2'd0:    b = rowreg[7:0];
            2'd1:    b = rowreg[15:8];
            default: b = rowreg[23:16];
        endcase
        return $signed(b);
    endfunction

endpackage
`default_nettype wire

// File: rtl/rc3_front.sv
`default_nettype none
module rc3_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire logic          i_mode,
    input  wire logic [31:0]   i_pix,
    output logic               o_busy,
    input  wire rc3_pkg::t_cfg i_cfg,
    output logic               o_job_valid,
    output rc3_pkg::t_job      o_job,
    input  wire logic          i_job_full
);

    rc3_pkg::t_front_state r_state, n_state;

    logic [rc3_pkg::ROW_W-1:0] r_row;
    logic [rc3_pkg::COL_W-1:0] r_col;
    logic [rc3_pkg::OPC_W-1:0] r_opc;
    logic                      r_real;
    logic                      r_retry;
    logic [31:0]               r_newpix;
    rc3_pkg::t_pix             r_win [9];

    rc3_pkg::t_pix r_upper [rc3_pkg::MAX_WIDTH];
    rc3_pkg::t_pix r_lower [rc3_pkg::MAX_WIDTH];
    rc3_pkg::t_pix r_up_q;
    rc3_pkg::t_pix r_lo_q;

    logic [rc3_pkg::DIM_W-1:0] w_w, w_h;
    logic                      w_drain_ok;
    logic                      w_emit_pre, w_emit_post, w_emit;
    logic                      w_step;
    logic                      w_wrap;
    logic [rc3_pkg::ROW_W-1:0] n_row;
    logic [rc3_pkg::COL_W-1:0] n_col;
    rc3_pkg::t_pix             w_nwin [9];
    rc3_pkg::t_pix             w_v [9];
    logic [rc3_pkg::ROW_W-1:0] w_orow;
    logic [rc3_pkg::DIM_W-1:0] w_ocol;
    logic [21:0]               w_area;

    assign w_w    = i_cfg.width;
    assign w_h    = i_cfg.height;
    assign w_area = w_w * w_h;

    // A drain tick only moves the stream once the frame is in and results remain.
    assign w_drain_ok = (r_row >= w_h) && ({1'b0, r_opc} < w_area) &&
                        ({1'b0, r_row} <= ({1'b0, w_h} + 12'd1));

    // Emission conditions for the current stream position.
    assign w_emit_pre  = (r_col == '0) && (r_row >= rc3_pkg::ROW_W'(2));
    assign w_emit_post = (r_col != '0) && (r_row != '0) && (r_row <= w_h);
    assign w_emit      = w_emit_pre || w_emit_post;
    assign w_step      = (r_state == rc3_pkg::F_STEP) && !(w_emit && i_job_full);

    // Window after the shift: the new right column comes from the line stores.
    always_comb begin
        for (int i = 0; i < 6; i++) begin
            w_nwin[i] = r_win[i+3];
        end
        w_nwin[6] = r_up_q;
        w_nwin[7] = r_lo_q;
        w_nwin[8] = r_newpix;
    end

    // Position counters after one step.
    assign w_wrap = (({1'b0, r_col} + rc3_pkg::DIM_W'(1)) >= w_w);
    always_comb begin
        if (w_wrap) begin
            n_col = '0;
            n_row = r_row + rc3_pkg::ROW_W'(1);
        end else begin
            n_col = r_col + rc3_pkg::COL_W'(1);
            n_row = r_row;
        end
    end

    // Pick the neighborhood and the position of the emitted pixel.
    always_comb begin
        if (w_emit_pre) begin
            for (int i = 0; i < 3; i++) begin
                w_v[i]   = r_win[i+3];
                w_v[i+3] = r_win[i+6];
                w_v[i+6] = r_win[i+6];
            end
            w_orow = r_row - rc3_pkg::ROW_W'(2);
            w_ocol = w_w - rc3_pkg::DIM_W'(1);
        end else begin
            w_v    = w_nwin;
            w_orow = r_row - rc3_pkg::ROW_W'(1);
            w_ocol = {1'b0, r_col} - rc3_pkg::DIM_W'(1);
        end
    end

    // Taps outside the image take the center pixel.
    always_comb begin
        logic rok, cok;
        for (int c = 0; c < 3; c++) begin
            for (int r = 0; r < 3; r++) begin
                rok = (r != 0 || w_orow >= rc3_pkg::ROW_W'(1)) &&
                      (r != 2 || ({1'b0, w_orow} + 12'd1) < {1'b0, w_h});
                cok = (c != 0 || w_ocol >= rc3_pkg::DIM_W'(1)) &&
                      (c != 2 || ({1'b0, w_ocol} + 12'd1) < {1'b0, w_w});
                o_job.pix[c*3+r] = (rok && cok) ? w_v[c*3+r] : w_v[4];
            end
        end
        o_job.row  = w_orow[9:0];
        o_job.col  = w_ocol[9:0];
        o_job.last = (w_orow == (w_h - rc3_pkg::DIM_W'(1))) &&
                     (w_ocol == (w_w - rc3_pkg::DIM_W'(1)));
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rc3_pkg::F_IDLE: begin
                if (i_push && (!i_mode || w_drain_ok)) begin
                    n_state = rc3_pkg::F_READ;
                end
            end
            rc3_pkg::F_READ: begin
                n_state = rc3_pkg::F_STEP;
            end
            rc3_pkg::F_STEP: begin
                if (w_step) begin
                    if (!r_real && !w_emit && r_retry &&
                        ({1'b0, n_row} <= ({1'b0, w_h} + 12'd1))) begin
                        n_state = rc3_pkg::F_READ;
                    end else begin
                        n_state = rc3_pkg::F_IDLE;
                    end
                end
            end
            default: n_state = rc3_pkg::F_IDLE;
        endcase
    end

    // Outputs of the sequencer.
    always_comb begin
        o_busy      = (r_state != rc3_pkg::F_IDLE);
        o_job_valid = w_step && w_emit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rc3_pkg::F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Stream position, window and request bookkeeping.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row   <= '0;
            r_col   <= '0;
            r_opc   <= '0;
            r_real  <= 1'b0;
            r_retry <= 1'b0;
            for (int i = 0; i < 9; i++) begin
                r_win[i] <= '0;
            end
        end else if (r_state == rc3_pkg::F_IDLE && i_push) begin
            if (!i_mode) begin
                if (r_row >= w_h) begin
                    r_row <= '0;
                    r_col <= '0;
                    r_opc <= '0;
                end
                r_real  <= 1'b1;
                r_retry <= 1'b0;
            end else if (w_drain_ok) begin
                r_real  <= 1'b0;
                r_retry <= 1'b1;
            end
        end else if (w_step) begin
            r_win   <= w_nwin;
            r_row   <= n_row;
            r_col   <= n_col;
            r_opc   <= r_opc + rc3_pkg::OPC_W'(w_emit);
            r_retry <= 1'b0;
        end
    end

    // Incoming pixel; a drain step shifts in zero.
    always_ff @(posedge i_clk) begin
        if (r_state == rc3_pkg::F_IDLE && i_push) begin
            r_newpix <= i_mode ? 32'd0 : i_pix;
        end
    end

    // Line stores: read in the read state ahead of the step, written when a real pixel steps.
    always_ff @(posedge i_clk) begin
        if (r_state == rc3_pkg::F_READ) begin
            r_up_q <= r_upper[r_col];
            r_lo_q <= r_lower[r_col];
        end
        if (w_step && r_real) begin
            r_upper[r_col] <= r_lo_q;
            r_lower[r_col] <= r_newpix;
        end
    end

endmodule
`default_nettype wire

// File: rtl/rc3_fifo.sv
`default_nettype none
module rc3_fifo (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire rc3_pkg::t_job i_data,
    output logic               o_full,
    input  wire logic          i_pop,
    output rc3_pkg::t_job      o_data,
    output logic               o_empty
);

    rc3_pkg::t_job r_mem [2];
    logic          r_wp, r_rp;
    logic [1:0]    r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rp];

    // Two-entry queue pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule
`default_nettype wire

// File: rtl/rc3_back.sv
`default_nettype none
module rc3_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire rc3_pkg::t_cfg i_cfg,
    input  wire logic          i_job_empty,
    input  wire rc3_pkg::t_job i_job,
    output logic               o_job_pop,
    output logic               o_empty,
    input  wire logic          i_pop,
    output logic [7:0]         o_red,
    output logic [7:0]         o_green,
    output logic [7:0]         o_blue,
    output logic [7:0]         o_alpha,
    output logic [9:0]         o_row,
    output logic [9:0]         o_col,
    output logic               o_last
);

    rc3_pkg::t_back_state r_state, n_state;

    rc3_pkg::t_job                   r_job;
    logic [3:0]                      r_k;
    logic [1:0]                      r_tr, r_tc;
    logic signed [rc3_pkg::ACC_W-1:0] r_acc [4];
    logic [rc3_pkg::REM_W-1:0]       r_rem [4];
    logic [7:0]                      r_q [4];
    logic                            r_sat [4];
    logic [2:0]                      r_bit;
    logic                            r_out_valid;
    logic                            w_load;
    logic signed [7:0]               w_coef;
    logic [31:0]                     w_pix;
    logic [rc3_pkg::REM_W-1:0]       w_trial;
    logic signed [rc3_pkg::ACC_W-1:0] w_limit;

    assign w_coef  = rc3_pkg::coef_sel(i_cfg, r_tr, r_tc);
    assign w_pix   = r_job.pix[r_k];
    assign w_trial = rc3_pkg::REM_W'({8'd0, i_cfg.divisor} << r_bit);
    assign w_limit = $signed({4'd0, i_cfg.divisor, 8'd0});

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rc3_pkg::B_IDLE: if (!i_job_empty) n_state = rc3_pkg::B_MAC;
            rc3_pkg::B_MAC:  if (r_k == 4'd8) n_state = rc3_pkg::B_PREP;
            rc3_pkg::B_PREP: n_state = rc3_pkg::B_DIV;
            rc3_pkg::B_DIV:  if (r_bit == 3'd0) n_state = rc3_pkg::B_HOLD;
            rc3_pkg::B_HOLD: if (!r_out_valid || i_pop) n_state = rc3_pkg::B_IDLE;
            default:         n_state = rc3_pkg::B_IDLE;
        endcase
    end

    // Outputs of the sequencer.
    always_comb begin
        o_job_pop = (r_state == rc3_pkg::B_IDLE) && !i_job_empty;
        w_load    = (r_state == rc3_pkg::B_HOLD) && (!r_out_valid || i_pop);
        o_empty   = !r_out_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rc3_pkg::B_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Multiply-accumulate one tap per cycle, then divide one quotient bit per cycle.
    always_ff @(posedge i_clk) begin
        logic signed [16:0] prod;
        unique case (r_state)
            rc3_pkg::B_IDLE: begin
                r_job <= i_job;
                r_k   <= '0;
                r_tr  <= '0;
                r_tc  <= '0;
                for (int ch = 0; ch < 4; ch++) begin
                    r_acc[ch] <= '0;
                end
            end
            rc3_pkg::B_MAC: begin
                for (int ch = 0; ch < 4; ch++) begin
                    prod = w_coef * $signed({1'b0, w_pix[ch*8 +: 8]});
                    r_acc[ch] <= r_acc[ch] + {{3{prod[16]}}, prod};
                end
                r_k <= r_k + 4'd1;
                if (r_tr == 2'd2) begin
                    r_tr <= '0;
                    r_tc <= r_tc + 2'd1;
                end else begin
                    r_tr <= r_tr + 2'd1;
                end
            end
            rc3_pkg::B_PREP: begin
                r_bit <= 3'd7;
                for (int ch = 0; ch < 4; ch++) begin
                    r_q[ch] <= '0;
                    if (r_acc[ch] <= 0) begin
                        r_sat[ch] <= 1'b0;
                        r_rem[ch] <= '0;
                    end else if (r_acc[ch] >= w_limit) begin
                        r_sat[ch] <= 1'b1;
                        r_rem[ch] <= '0;
                    end else begin
                        r_sat[ch] <= 1'b0;
                        r_rem[ch] <= r_acc[ch][rc3_pkg::REM_W-1:0];
                    end
                end
            end
            rc3_pkg::B_DIV: begin
                for (int ch = 0; ch < 4; ch++) begin
                    if (r_rem[ch] >= w_trial) begin
                        r_rem[ch]       <= r_rem[ch] - w_trial;
                        r_q[ch][r_bit] <= 1'b1;
                    end
                end
                r_bit <= r_bit - 3'd1;
            end
            rc3_pkg::B_HOLD: begin
            end
            default: begin
            end
        endcase
    end

    // Result register toward the output queue port.
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            o_red   <= r_sat[0] ? 8'hFF : r_q[0];
            o_green <= r_sat[1] ? 8'hFF : r_q[1];
            o_blue  <= r_sat[2] ? 8'hFF : r_q[2];
            o_alpha <= r_sat[3] ? 8'hFF : r_q[3];
            o_row   <= r_job.row;
            o_col   <= r_job.col;
            o_last  <= r_job.last;
        end
    end

endmodule
`default_nettype wire

// File: rtl/rgba_3x3_convolution.sv
// Channel   Direction  Handshake            Payload
// pixel     in         push / full          i_mode, i_red, i_green, i_blue, i_alpha
// result    out        empty / pop          o_out_red .. o_out_alpha, o_out_row,
//                                           o_out_col, o_frame_last
// config    in         i_cfg_we             i_cfg_idx, i_cfg_data
//
// A pixel item goes through accept, line store read and step, so full is high from the read
// through the step plus any queue stall; an ignored drain tick never raises full, and one
// that steps twice goes through read and step twice.
// In the back end each result goes through taking the request, multiply-accumulate over the
// nine taps, a setup step, bit-serial division of the quotient bits and the load.
// A full request queue stalls the front; a finished result waits in the output register.
// Reset is synchronous; the line stores are not cleared and need no clearing pass.
`default_nettype none
`include "rgba_3x3_convolution_assert.svh"
module rgba_3x3_convolution (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic        i_mode,
    input  wire logic [7:0]  i_red,
    input  wire logic [7:0]  i_green,
    input  wire logic [7:0]  i_blue,
    input  wire logic [7:0]  i_alpha,
    output logic             empty,
    input  wire logic        pop,
    output logic [7:0]       o_out_red,
    output logic [7:0]       o_out_green,
    output logic [7:0]       o_out_blue,
    output logic [7:0]       o_out_alpha,
    output logic [9:0]       o_out_row,
    output logic [9:0]       o_out_col,
    output logic             o_frame_last,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [23:0] i_cfg_data
);

    logic [rc3_pkg::DIM_W-1:0] r_width, r_height;
    logic [23:0]               r_coef_top, r_coef_mid, r_coef_bot;
    logic [7:0]                r_divisor;
    rc3_pkg::t_cfg             w_cfg;

    logic          w_busy;
    logic          w_q_push, w_q_full, w_q_pop, w_q_empty;
    rc3_pkg::t_job w_q_in, w_q_out;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width    <= rc3_pkg::DIM_W'(1024);
            r_height   <= rc3_pkg::DIM_W'(1024);
            r_coef_top <= 24'd0;
            r_coef_mid <= 24'd256;
            r_coef_bot <= 24'd0;
            r_divisor  <= 8'd1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                rc3_pkg::CFG_WIDTH:  r_width    <= i_cfg_data[rc3_pkg::DIM_W-1:0];
                rc3_pkg::CFG_HEIGHT: r_height   <= i_cfg_data[rc3_pkg::DIM_W-1:0];
                rc3_pkg::CFG_TOP:    r_coef_top <= i_cfg_data;
                rc3_pkg::CFG_MID:    r_coef_mid <= i_cfg_data;
                rc3_pkg::CFG_BOT:    r_coef_bot <= i_cfg_data;
                rc3_pkg::CFG_DIV:    r_divisor  <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    // Clamp the written values to what the datapath supports.
    always_comb begin
        w_cfg.width    = rc3_pkg::eff_dim(r_width);
        w_cfg.height   = rc3_pkg::eff_dim(r_height);
        w_cfg.coef_top = r_coef_top;
        w_cfg.coef_mid = r_coef_mid;
        w_cfg.coef_bot = r_coef_bot;
        w_cfg.divisor  = (r_divisor == 8'd0) ? 8'd1 : r_divisor;
    end

    assign full = w_busy;

    rc3_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push && !w_busy),
        .i_mode      (i_mode),
        .i_pix       ({i_alpha, i_blue, i_green, i_red}),
        .o_busy      (w_busy),
        .i_cfg       (w_cfg),
        .o_job_valid (w_q_push),
        .o_job       (w_q_in),
        .i_job_full  (w_q_full)
    );

    rc3_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_data  (w_q_in),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_data  (w_q_out),
        .o_empty (w_q_empty)
    );

    rc3_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_job_empty (w_q_empty),
        .i_job       (w_q_out),
        .o_job_pop   (w_q_pop),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_red       (o_out_red),
        .o_green     (o_out_green),
        .o_blue      (o_out_blue),
        .o_alpha     (o_out_alpha),
        .o_row       (o_out_row),
        .o_col       (o_out_col),
        .o_last      (o_frame_last)
    );

    // The front never pushes a request into a full queue.
    `RC3_ASSERT_NEVER(a_q_no_overflow, w_q_push && w_q_full, "request queue overflow")
    // The back only takes a request that is there.
    `RC3_ASSERT_IMPLIES(a_q_no_underflow, w_q_pop, !w_q_empty, "request queue underflow")

endmodule
`default_nettype wire

// File: dv/tb.sv
`default_nettype none
module tb;

    localparam bit MODE_PIXEL = 1'b0;
    localparam bit MODE_DRAIN = 1'b1;
    localparam int CYCLE_LIMIT = 3000000;
    localparam int LONG_HOLD = 500;

    // One filtered output pixel with its position.
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic [9:0] row;
        logic [9:0] col;
        logic       last;
    } t_conv_result;

    // One row of the directed stimulus; the expected pixel is typed in where known.
    typedef struct packed {
        logic        mode;
        logic [31:0] pix;
        logic        typed;
        logic [31:0] exp_pix;
        logic [9:0]  exp_row;
        logic [9:0]  exp_col;
        logic        exp_last;
    } t_stim_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic        i_mode = 1'b0;
    logic [7:0]  i_red = '0;
    logic [7:0]  i_green = '0;
    logic [7:0]  i_blue = '0;
    logic [7:0]  i_alpha = '0;
    logic        empty;
    logic        pop = 1'b0;
    logic [7:0]  o_out_red;
    logic [7:0]  o_out_green;
    logic [7:0]  o_out_blue;
    logic [7:0]  o_out_alpha;
    logic [9:0]  o_out_row;
    logic [9:0]  o_out_col;
    logic        o_frame_last;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_idx = '0;
    logic [23:0] i_cfg_data = '0;

    rgba_3x3_convolution i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .push(push), .full(full), .i_mode(i_mode),
        .i_red(i_red), .i_green(i_green), .i_blue(i_blue), .i_alpha(i_alpha),
        .empty(empty), .pop(pop), .o_out_red(o_out_red), .o_out_green(o_out_green),
        .o_out_blue(o_out_blue), .o_out_alpha(o_out_alpha), .o_out_row(o_out_row),
        .o_out_col(o_out_col), .o_frame_last(o_frame_last), .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    // Filter state mirrored in the testbench.
    logic [31:0]      upper_line [rc3_pkg::MAX_WIDTH];
    logic [31:0]      lower_line [rc3_pkg::MAX_WIDTH];
    logic [8:0][31:0] window = '0;
    int unsigned      row_pos = 0;
    int unsigned      col_pos = 0;
    int unsigned      frame_results = 0;
    logic [10:0]      width_reg = 11'd1024;
    logic [10:0]      height_reg = 11'd1024;
    logic [23:0]      taps_top = '0;
    logic [23:0]      taps_mid = 24'h000100;
    logic [23:0]      taps_bot = '0;
    logic [7:0]       divisor_reg = 8'd1;

    t_conv_result pending_pixels[$];
    int           errors = 0;
    int           checked = 0;
    int           cycles = 0;
    int           random_pixels = 0;
    bit           steady = 1'b0;
    int           hold_requests = 0;

    function automatic int unsigned clamp_dim(input logic [10:0] v);
        if (v == '0) return 1;
        if (v > 11'd1024) return 1024;
        return 32'(v);
    endfunction

    // Convolve one neighborhood, indexed col*3 + row, and normalize each channel.
    function automatic t_conv_result filter_window(input logic [8:0][31:0] v,
                                                   input int unsigned orow,
                                                   input int unsigned ocol);
        int unsigned  w;
        int unsigned  h;
        int unsigned  d;
        int           sum [4];
        int           k;
        int unsigned  q;
        bit           row_ok;
        bit           col_ok;
        logic [31:0]  pix;
        logic [23:0]  taps;
        logic [7:0]   chan [4];
        t_conv_result res;
        w = clamp_dim(width_reg);
        h = clamp_dim(height_reg);
        d = (divisor_reg == '0) ? 1 : divisor_reg;
        for (int ch = 0; ch < 4; ch++) sum[ch] = 0;
        for (int r = 0; r < 3; r++) begin
            taps = (r == 0) ? taps_top : (r == 1) ? taps_mid : taps_bot;
            for (int c = 0; c < 3; c++) begin
                row_ok = (r != 0 || orow >= 1) && (r != 2 || orow + 1 < h);
                col_ok = (c != 0 || ocol >= 1) && (c != 2 || ocol + 1 < w);
                pix = (row_ok && col_ok) ? v[c * 3 + r] : v[4];
                k = int'($signed(taps[8 * c +: 8]));
                for (int ch = 0; ch < 4; ch++) sum[ch] += k * int'(pix[8 * ch +: 8]);
            end
        end
        // Negative sums give zero; positive ones divide, truncate and saturate.
        for (int ch = 0; ch < 4; ch++) begin
            q = 0;
            if (sum[ch] > 0) begin
                q = int'(sum[ch]) / d;
                if (q > 255) q = 255;
            end
            chan[ch] = q[7:0];
        end
        res.red = chan[0];
        res.green = chan[1];
        res.blue = chan[2];
        res.alpha = chan[3];
        res.row = orow[9:0];
        res.col = ocol[9:0];
        res.last = (orow == h - 1 && ocol == w - 1);
        frame_results++;
        return res;
    endfunction

    // Move the stream position by one pixel; the line stores change only for real pixels.
    function automatic bit advance_position(input logic [31:0] newpix, input bit is_pixel,
                                            output t_conv_result res);
        int unsigned      w;
        int unsigned      h;
        int unsigned      rr;
        int unsigned      cc;
        int unsigned      col;
        bit               got;
        logic [8:0][31:0] v;
        w = clamp_dim(width_reg);
        h = clamp_dim(height_reg);
        rr = row_pos;
        cc = col_pos;
        col = cc % rc3_pkg::MAX_WIDTH;
        got = 1'b0;
        res = '0;
        // The last column of the row two back completes at the start of a row.
        if (cc == 0 && rr >= 2) begin
            for (int i = 0; i < 6; i++) v[i] = window[i + 3];
            for (int i = 6; i < 9; i++) v[i] = window[i];
            res = filter_window(v, rr - 2, w - 1);
            got = 1'b1;
        end
        for (int i = 0; i < 6; i++) window[i] = window[i + 3];
        window[6] = upper_line[col];
        window[7] = lower_line[col];
        window[8] = newpix;
        if (is_pixel) begin
            upper_line[col] = lower_line[col];
            lower_line[col] = newpix;
        end
        if (cc >= 1 && rr >= 1 && rr <= h) begin
            res = filter_window(window, rr - 1, cc - 1);
            got = 1'b1;
        end
        if (cc + 1 >= w) begin
            col_pos = 0;
            row_pos = rr + 1;
        end else begin
            col_pos = cc + 1;
        end
        return got;
    endfunction

    // Expected outcome of one accepted request.
    function automatic bit predict_request(input bit mode, input logic [31:0] pix,
                                           output t_conv_result res);
        int unsigned w;
        int unsigned h;
        w = clamp_dim(width_reg);
        h = clamp_dim(height_reg);
        res = '0;
        if (mode == MODE_PIXEL) begin
            // A pixel after a complete frame opens a new frame.
            if (row_pos >= h) begin
                row_pos = 0;
                col_pos = 0;
                frame_results = 0;
            end
            return advance_position(pix, 1'b1, res);
        end
        if (row_pos >= h && frame_results < w * h) begin
            for (int k = 0; k < 2 && row_pos <= h + 1; k++) begin
                if (advance_position('0, 1'b0, res)) return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    task automatic report_mismatch(input string field, input int got, input int want);
        $display("mismatch at result %0d: %s got %0d expected %0d", checked, field, got, want);
        errors++;
    endtask

    // Cycle counter and timeout.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("rgba_3x3_convolution verification failed");
            $finish;
        end
    end

    // Result side: check each popped result and pace pop with random holds.
    int unsigned  hold_cnt = 0;
    int           holds_served = 0;
    int unsigned  pick;
    t_conv_result want;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                if (pending_pixels.size() == 0) begin
                    report_mismatch("unexpected result, row", o_out_row, -1);
                end else begin
                    want = pending_pixels.pop_front();
                    if (o_out_red !== want.red) report_mismatch("red", o_out_red, want.red);
                    if (o_out_green !== want.green)
                        report_mismatch("green", o_out_green, want.green);
                    if (o_out_blue !== want.blue) report_mismatch("blue", o_out_blue, want.blue);
                    if (o_out_alpha !== want.alpha)
                        report_mismatch("alpha", o_out_alpha, want.alpha);
                    if (o_out_row !== want.row) report_mismatch("row", o_out_row, want.row);
                    if (o_out_col !== want.col) report_mismatch("col", o_out_col, want.col);
                    if (o_frame_last !== want.last)
                        report_mismatch("frame_last", o_frame_last, want.last);
                end
                checked++;
            end
            if (holds_served < hold_requests) begin
                holds_served++;
                hold_cnt = LONG_HOLD;
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                pop <= 1'b0;
            end else if (steady) begin
                pop <= 1'b1;
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 65) begin
                    pop <= 1'b1;
                end else begin
                    pop <= 1'b0;
                    hold_cnt = (pick < 97) ? $urandom_range(0, 3) : $urandom_range(15, 60);
                end
            end
        end
    end

    function automatic int unsigned sender_gap();
        int unsigned pick;
        if (steady) return 0;
        pick = $urandom_range(0, 99);
        if (pick < 60) return 0;
        if (pick < 96) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Offer one request, wait for it to be taken, then record its expected result.
    task automatic send_request(input bit mode, input logic [31:0] pix,
                                input bit typed = 1'b0, input t_conv_result typed_res = '0);
        t_conv_result res;
        bit           got;
        int unsigned  gap;
        push <= 1'b1;
        i_mode <= mode;
        {i_alpha, i_blue, i_green, i_red} <= pix;
        do @(posedge i_clk); while (full);
        got = predict_request(mode, pix, res);
        if (typed) begin
            if (!got) report_mismatch("directed row gives no result, row", 0, typed_res.row);
            else pending_pixels.push_back(typed_res);
        end else if (got) begin
            pending_pixels.push_back(res);
        end
        gap = sender_gap();
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Let every expected result arrive, plus time for a drain still stepping.
    task automatic wait_idle();
        push <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_config(input logic [10:0] w, input logic [10:0] h,
                                input logic [23:0] top, input logic [23:0] mid,
                                input logic [23:0] bot, input logic [7:0] div);
        logic [23:0] vals [6];
        logic [2:0]  idxs [6];
        vals = '{24'(w), 24'(h), top, mid, bot, 24'(div)};
        idxs = '{rc3_pkg::CFG_WIDTH, rc3_pkg::CFG_HEIGHT, rc3_pkg::CFG_TOP,
                 rc3_pkg::CFG_MID, rc3_pkg::CFG_BOT, rc3_pkg::CFG_DIV};
        for (int i = 0; i < 6; i++) begin
            i_cfg_we <= 1'b1;
            i_cfg_idx <= idxs[i];
            i_cfg_data <= vals[i];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        width_reg = w;
        height_reg = h;
        taps_top = top;
        taps_mid = mid;
        taps_bot = bot;
        divisor_reg = div;
    endtask

    // Stream whole frames of random pixels with stray drains and short flushes mixed in.
    task automatic stream_frames(input int nframes);
        int unsigned w;
        int unsigned h;
        int unsigned flushes;
        w = clamp_dim(width_reg);
        h = clamp_dim(height_reg);
        for (int f = 0; f < nframes; f++) begin
            for (int unsigned p = 0; p < w * h; p++) begin
                if ($urandom_range(0, 24) == 0) send_request(MODE_DRAIN, $urandom());
                send_request(MODE_PIXEL, $urandom());
                random_pixels++;
            end
            // Only the last frame must be flushed completely before a new setting.
            flushes = w + 3;
            if (f < nframes - 1 && $urandom_range(0, 3) == 0) flushes = $urandom_range(0, w);
            for (int unsigned k = 0; k < flushes; k++) send_request(MODE_DRAIN, $urandom());
        end
    endtask

    t_stim_row    directed [21];
    int unsigned  w_pick;
    int unsigned  h_pick;
    logic [7:0]   div_pick;
    t_conv_result typed_res;

    initial begin
        // Identity kernel on a 2x2 frame: each output equals its input pixel.
        directed = '{
            '{MODE_PIXEL, 32'h00000000, 1'b0, 32'h0, 10'd0, 10'd0, 1'b0},
            '{MODE_PIXEL, 32'hFFFFFFFF, 1'b0, 32'h0, 10'd0, 10'd0, 1'b0},
            '{MODE_PIXEL, 32'h80A55A01, 1'b0, 32'h0, 10'd0, 10'd0, 1'b0},
            '{MODE_PIXEL, 32'h7F0102FE, 1'b1, 32'h00000000, 10'd0, 10'd0, 1'b0},
            '{MODE_DRAIN, 32'h00000000, 1'b1, 32'hFFFFFFFF, 10'd0, 10'd1, 1'b0},
            '{MODE_DRAIN, 32'hFFFFFFFF, 1'b1, 32'h80A55A01, 10'd1, 10'd0, 1'b0},
            '{MODE_DRAIN, 32'h00000000, 1'b1, 32'h7F0102FE, 10'd1, 10'd1, 1'b1},
            // Nothing left to flush.
            '{MODE_DRAIN, 32'h00000000, 1'b0, 32'h0, 10'd0, 10'd0, 1'b0},
            '{MODE_PIXEL, 32'h11223344, 1'b0, 32'h0, 10'd0, 10'd0, 1'b0},
            '{MODE_PIXEL, 32'hFEDCBA98, 1'b0, 32'h0, 10'd0, 10'd0, 1'b0},
            '{MODE_PIXEL, 32'h01010101, 1'b0, 32'h0, 10'd0, 10'd0, 1'b0},
            '{MODE_PIXEL, 32'hFF00FF00, 1'b0, 32'h0, 10'd0, 10'd0, 1'b0},
            // New frame before the flush: the pending results are dropped.
            '{MODE_PIXEL, 32'h00FF00FF, 1'b0, 32'h0, 10'd0, 10'd0, 1'b0},
            // Drain inside an unfinished frame is ignored.
            '{MODE_DRAIN, 32'hFFFFFFFF, 1'b0, 32'h0, 10'd0, 10'd0, 1'b0},
            '{MODE_PIXEL, 32'h5A5A5A5A, 1'b0, 32'h0, 10'd0, 10'd0, 1'b0},
            '{MODE_PIXEL, 32'hA5A5A5A5, 1'b0, 32'h0, 10'd0, 10'd0, 1'b0},
            '{MODE_PIXEL, 32'hC0FFEE00, 1'b0, 32'h0, 10'd0, 10'd0, 1'b0},
            '{MODE_DRAIN, 32'h00000000, 1'b0, 32'h0, 10'd0, 10'd0, 1'b0},
            '{MODE_DRAIN, 32'h00000000, 1'b0, 32'h0, 10'd0, 10'd0, 1'b0},
            '{MODE_DRAIN, 32'h00000000, 1'b0, 32'h0, 10'd0, 10'd0, 1'b0},
            '{MODE_DRAIN, 32'h00000000, 1'b0, 32'h0, 10'd0, 10'd0, 1'b0}
        };
        for (int i = 0; i < rc3_pkg::MAX_WIDTH; i++) begin
            upper_line[i] = '0;
            lower_line[i] = '0;
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part.
        write_config(11'd2, 11'd2, 24'h0, 24'h000100, 24'h0, 8'd1);
        foreach (directed[i]) begin
            typed_res = {directed[i].exp_pix[7:0], directed[i].exp_pix[15:8],
                         directed[i].exp_pix[23:16], directed[i].exp_pix[31:24],
                         directed[i].exp_row, directed[i].exp_col, directed[i].exp_last};
            send_request(directed[i].mode, directed[i].pix, directed[i].typed, typed_res);
        end
        wait_idle();

        // Extreme settings: zero sizes and divisor, an oversize height giving the tallest
        // frame, most negative and most positive taps.
        write_config(11'd0, 11'd0, 24'($urandom()), 24'($urandom()), 24'($urandom()), 8'd0);
        stream_frames(3);
        wait_idle();
        steady = 1'b1;
        write_config(11'd1, 11'd2047, 24'h010101, 24'h010201, 24'h010101, 8'd9);
        stream_frames(1);
        wait_idle();
        steady = 1'b0;
        write_config(11'd20, 11'd3, 24'($urandom()), 24'($urandom()), 24'($urandom()), 8'd3);
        hold_requests++;
        stream_frames(1);
        wait_idle();
        write_config(11'd5, 11'd4, 24'h808080, 24'h808080, 24'h808080, 8'd1);
        stream_frames(2);
        wait_idle();
        write_config(11'd4, 11'd5, 24'h7F7F7F, 24'h7F7F7F, 24'h7F7F7F, 8'd1);
        stream_frames(2);
        wait_idle();
        write_config(11'd3, 11'd3, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 8'd1);
        stream_frames(2);
        wait_idle();

        // Random settings, mostly small frames.
        random_pixels = 0;
        while (random_pixels < 100) begin
            w_pick = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 6);
            h_pick = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 20) : $urandom_range(1, 6);
            div_pick = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(1, 4)) :
                                                     8'($urandom_range(0, 255));
            steady = ($urandom_range(0, 5) == 0);
            write_config(11'(w_pick), 11'(h_pick), 24'($urandom()), 24'($urandom()),
                         24'($urandom()), div_pick);
            if ($urandom_range(0, 7) == 0) hold_requests++;
            stream_frames($urandom_range(1, 3));
            wait_idle();
        end
        steady = 1'b0;

        repeat (100) @(posedge i_clk);
        if (errors == 0 && pending_pixels.size() == 0) begin
            $display("rgba_3x3_convolution verification clean");
        end else begin
            $display("rgba_3x3_convolution verification failed");
        end
        $finish;
    end
endmodule
`default_nettype wire
